/* src/point_frustum_test_assert.svh */
// Assertion macros for the point frustum test checker.
// Clock aclk and active-low reset aresetn are taken from the including scope.
`ifndef POINT_FRUSTUM_TEST_ASSERT_SVH
`define POINT_FRUSTUM_TEST_ASSERT_SVH

// Same-cycle implication
`define PFT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PFT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pft_pkg.sv */
// Shared constants and types for the point frustum test block.
// No dependencies.
package pft_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int BASIS_W         = 16;   // Q2.14 basis component
    localparam int TAN_W           = 16;   // Q4.12 tangent
    localparam int LIMIT_W         = 16;   // Q8.8 near/far
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_IDX_W       = 3;
    localparam int DEPTH_FRAC_DROP = 14;   // Q.22 dot product -> Q8.8 depth
    localparam int BOUND_SHIFT     = 2;    // Q.20 bound -> Q.22
    localparam int M_TDATA_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_RIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_UP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_FORWARD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_HEIGHT = 3'd7;

    localparam logic [LIMIT_W-1:0] FAR_LIMIT_RESET = 16'h7FFF;
    localparam logic [TAN_W-1:0]   TAN_RESET       = 16'd4096;

    // Load enables for the two stages of a dot-product unit
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } pft_dot_en_t;

endpackage

/* src/pft_dot3.sv */
// Two-stage dot product of a signed difference vector with a packed basis vector.
// Depends on pft_pkg.
module pft_dot3 import pft_pkg::*; #(
    parameter int DIFF_W = COORD_WIDTH_DEF + 1,
    localparam int PROD_W = DIFF_W + BASIS_W,
    localparam int DOT_W  = PROD_W + 2
) (
    input  logic                        aclk,
    input  pft_dot_en_t                 en,
    input  logic signed [DIFF_W-1:0]    d_x,
    input  logic signed [DIFF_W-1:0]    d_y,
    input  logic signed [DIFF_W-1:0]    d_z,
    input  logic [3*BASIS_W-1:0]        basis,   // x, y, z from bit 0
    output logic signed [DOT_W-1:0]     dot
);

    logic signed [BASIS_W-1:0] b_x, b_y, b_z;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [DOT_W-1:0]   dot_reg;

    assign b_x = signed'(basis[0*BASIS_W +: BASIS_W]);
    assign b_y = signed'(basis[1*BASIS_W +: BASIS_W]);
    assign b_z = signed'(basis[2*BASIS_W +: BASIS_W]);

    always_ff @(posedge aclk) begin
        if (en.mul_en) begin
            prod_x_reg <= PROD_W'(d_x) * PROD_W'(b_x);
            prod_y_reg <= PROD_W'(d_y) * PROD_W'(b_y);
            prod_z_reg <= PROD_W'(d_z) * PROD_W'(b_z);
        end
        if (en.sum_en) begin
            dot_reg <= DOT_W'(prod_x_reg) + DOT_W'(prod_y_reg) + DOT_W'(prod_z_reg);
        end
    end

    assign dot = dot_reg;

endmodule

/* src/point_frustum_test.sv */
// Point-in-frustum culling pipeline: top level with config registers and stage control.
// Depends on pft_pkg and pft_dot3.
//
// One world point enters per clock when the output side keeps up, and its inside/outside
// verdict leaves through these stages in order: camera subtract, three parallel
// 16-bit-basis multiplies, dot-product sums, depth/bound multiply with near/far
// check, and the final magnitude compare each own a register stage. Every stage
// holds its item only while the stage after it is full and stalled, so bubbles
// close up and s_tready drops only when all five stages hold items.
// Configuration writes must happen while no items are in flight.
module point_frustum_test import pft_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int S_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_idx,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,   // point_x, point_y, point_z
    input  logic                    s_tlast,   // end_of_batch
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // inside_res
    output logic                    m_tlast    // batch_done
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int DOT_W  = DIFF_W + BASIS_W + 2;
    localparam int Z8_W   = DOT_W - DEPTH_FRAC_DROP;
    localparam int RNG_W  = (Z8_W > LIMIT_W) ? Z8_W : LIMIT_W;
    localparam int BOUND_W = TAN_W + 1 + Z8_W;
    localparam int CMP_W  = BOUND_W + BOUND_SHIFT;
    localparam int POS_W  = (3 * COORD_WIDTH > CFG_DATA_W) ? 3 * COORD_WIDTH : CFG_DATA_W;

    // Configuration registers
    logic [CFG_DATA_W-1:0] cam_pos_reg, right_reg, up_reg, fwd_reg;
    logic [LIMIT_W-1:0]    near_reg, far_reg;
    logic [TAN_W-1:0]      tan_w_reg, tan_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_pos_reg <= '0;
            right_reg   <= '0;
            up_reg      <= '0;
            fwd_reg     <= '0;
            near_reg    <= '0;
            far_reg     <= FAR_LIMIT_RESET;
            tan_w_reg   <= TAN_RESET;
            tan_h_reg   <= TAN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_CAMERA_POSITION: cam_pos_reg <= cfg_data;
                REG_BASIS_RIGHT:     right_reg   <= cfg_data;
                REG_BASIS_UP:        up_reg      <= cfg_data;
                REG_BASIS_FORWARD:   fwd_reg     <= cfg_data;
                REG_NEAR_LIMIT:      near_reg    <= cfg_data[LIMIT_W-1:0];
                REG_FAR_LIMIT:       far_reg     <= cfg_data[LIMIT_W-1:0];
                REG_TAN_HALF_WIDTH:  tan_w_reg   <= cfg_data[TAN_W-1:0];
                REG_TAN_HALF_HEIGHT: tan_h_reg   <= cfg_data[TAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Camera components sit at a stride of COORD_WIDTH; bits past the register read as zero
    logic [POS_W-1:0]              cam_wide;
    logic signed [COORD_WIDTH-1:0] cam_x, cam_y, cam_z;
    logic signed [COORD_WIDTH-1:0] pt_x, pt_y, pt_z;

    assign cam_wide = POS_W'(cam_pos_reg);
    assign cam_x = signed'(cam_wide[0*COORD_WIDTH +: COORD_WIDTH]);
    assign cam_y = signed'(cam_wide[1*COORD_WIDTH +: COORD_WIDTH]);
    assign cam_z = signed'(cam_wide[2*COORD_WIDTH +: COORD_WIDTH]);
    assign pt_x  = signed'(s_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
    assign pt_y  = signed'(s_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
    assign pt_z  = signed'(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]);

    // Stage control: a stage loads when it is empty or the next one loads
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: difference from camera
    logic signed [DIFF_W-1:0] d_x_reg, d_y_reg, d_z_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg, last5_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            d_x_reg   <= DIFF_W'(pt_x) - DIFF_W'(cam_x);
            d_y_reg   <= DIFF_W'(pt_y) - DIFF_W'(cam_y);
            d_z_reg   <= DIFF_W'(pt_z) - DIFF_W'(cam_z);
            last1_reg <= s_tlast;
        end
        if (en2) last2_reg <= last1_reg;
        if (en3) last3_reg <= last2_reg;
        if (en4) last4_reg <= last3_reg;
        if (en5) last5_reg <= last4_reg;
    end

    // Stages 2 and 3: products and sums
    pft_dot_en_t             dot_en;
    logic signed [DOT_W-1:0] dot_rt, dot_up, dot_fw;

    assign dot_en = '{mul_en: en2, sum_en: en3};

    pft_dot3 #(.DIFF_W(DIFF_W)) u_dot_right (
        .aclk(aclk), .en(dot_en), .d_x(d_x_reg), .d_y(d_y_reg), .d_z(d_z_reg),
        .basis(right_reg), .dot(dot_rt)
    );

    pft_dot3 #(.DIFF_W(DIFF_W)) u_dot_up (
        .aclk(aclk), .en(dot_en), .d_x(d_x_reg), .d_y(d_y_reg), .d_z(d_z_reg),
        .basis(up_reg), .dot(dot_up)
    );

    pft_dot3 #(.DIFF_W(DIFF_W)) u_dot_fwd (
        .aclk(aclk), .en(dot_en), .d_x(d_x_reg), .d_y(d_y_reg), .d_z(d_z_reg),
        .basis(fwd_reg), .dot(dot_fw)
    );

    // Stage 4: depth (floor to Q8.8), near/far window, bounds, magnitudes
    logic signed [Z8_W-1:0]    z8;
    logic signed [RNG_W-1:0]   z8_r, near_r, far_r;
    logic signed [BOUND_W-1:0] bound_x_reg, bound_y_reg;
    logic [DOT_W-1:0]          mag_x_reg, mag_y_reg;
    logic                      range_ok_reg;

    assign z8     = signed'(dot_fw[DOT_W-1:DEPTH_FRAC_DROP]);
    assign z8_r   = RNG_W'(z8);
    assign near_r = RNG_W'(signed'(near_reg));
    assign far_r  = RNG_W'(signed'(far_reg));

    always_ff @(posedge aclk) begin
        if (en4) begin
            range_ok_reg <= (z8_r >= near_r) && (z8_r <= far_r);
            bound_x_reg  <= BOUND_W'(signed'({1'b0, tan_w_reg})) * BOUND_W'(z8);
            bound_y_reg  <= BOUND_W'(signed'({1'b0, tan_h_reg})) * BOUND_W'(z8);
            // most negative value wraps to itself, which reads right as unsigned
            mag_x_reg    <= dot_rt[DOT_W-1] ? (~dot_rt + 1'b1) : dot_rt;
            mag_y_reg    <= dot_up[DOT_W-1] ? (~dot_up + 1'b1) : dot_up;
        end
    end

    // Stage 5: compare magnitudes with bounds scaled to Q.22
    logic signed [CMP_W-1:0] mag_x_s, mag_y_s, lim_x_s, lim_y_s;
    logic                    inside_reg;

    assign mag_x_s = signed'(CMP_W'(mag_x_reg));
    assign mag_y_s = signed'(CMP_W'(mag_y_reg));
    assign lim_x_s = signed'({bound_x_reg, {BOUND_SHIFT{1'b0}}});
    assign lim_y_s = signed'({bound_y_reg, {BOUND_SHIFT{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en5) begin
            inside_reg <= range_ok_reg && (mag_x_s <= lim_x_s) && (mag_y_s <= lim_y_s);
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, inside_reg};
    assign m_tlast  = last5_reg;

endmodule

/* src/pft_checker.sv */
// Port-level checks for point_frustum_test, bound to the top level.
// Depends on pft_pkg and point_frustum_test_assert.svh.
`include "point_frustum_test_assert.svh"

module pft_checker import pft_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // a stalled result item holds
    `PFT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // when the output stage can move, the whole pipe can take an item
    `PFT_ASSERT_IMP(a_ready_flow, !m_tvalid || m_tready, s_tready, "input stalled while output free")

    // reset empties the pipeline
    `PFT_ASSERT_IMP(a_reset_empty, !$past(aresetn), !m_tvalid, "output valid right after reset")

    // padding bits above the verdict stay zero
    `PFT_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:1] == '0, "output padding not zero")

endmodule

bind point_frustum_test pft_checker u_pft_checker (.*);

/* dv/frustum_verdict_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the point frustum test block: tracks config writes, predicts
// the inside/outside verdict of every accepted point and checks each result item.
// Depends on pft_pkg.
module frustum_verdict_checker import pft_pkg::*; #(
    parameter int COORD_W = COORD_WIDTH_DEF,
    localparam int S_W = ((3 * COORD_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_W-1:0]        s_tdata,   // point_x, point_y, point_z
    input  logic                  s_tlast,   // end_of_batch
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // inside_res
    input  logic                  m_tlast,   // batch_done
    output int                    verdicts_due,
    output int                    mismatches
);

    localparam int PRINT_CAP = 100;
    localparam int CAM_EXT_W = 3 * COORD_W + CFG_DATA_W;

    typedef struct packed {
        logic in_view;
        logic batch_done;
    } verdict_t;

    logic [CFG_DATA_W-1:0] cam_pos;
    logic [CFG_DATA_W-1:0] right_vec;
    logic [CFG_DATA_W-1:0] up_vec;
    logic [CFG_DATA_W-1:0] fwd_vec;
    logic [LIMIT_W-1:0]    near_lim;
    logic [LIMIT_W-1:0]    far_lim;
    logic [TAN_W-1:0]      tan_w;
    logic [TAN_W-1:0]      tan_h;
    verdict_t              verdict_q[$];

    // Exact dot product of a camera-relative offset with one packed Q2.14 axis
    function automatic longint project(input longint dx, input longint dy, input longint dz,
                                       input logic [CFG_DATA_W-1:0] axis);
        return dx * longint'($signed(axis[0 +: BASIS_W]))
             + dy * longint'($signed(axis[BASIS_W +: BASIS_W]))
             + dz * longint'($signed(axis[2*BASIS_W +: BASIS_W]));
    endfunction

    function automatic logic frustum_inside(input logic [S_W-1:0] pt);
        logic [CAM_EXT_W-1:0] cam_ext;
        longint rel [3];
        longint depth;
        longint lat;
        longint vert;
        longint reach_x;
        longint reach_y;
        cam_ext = CAM_EXT_W'(cam_pos);   // position bits past the register read as zero
        for (int i = 0; i < 3; i++) begin
            rel[i] = longint'($signed(pt[i*COORD_W +: COORD_W]))
                   - longint'($signed(cam_ext[i*COORD_W +: COORD_W]));
        end
        // Q.22 -> Q8.8, rounding toward minus infinity
        depth = project(rel[0], rel[1], rel[2], fwd_vec) >>> DEPTH_FRAC_DROP;
        if (depth < $signed(near_lim) || depth > $signed(far_lim)) begin
            return 1'b0;
        end
        lat     = project(rel[0], rel[1], rel[2], right_vec);
        vert    = project(rel[0], rel[1], rel[2], up_vec);
        reach_x = longint'(tan_w);
        reach_y = longint'(tan_h);
        reach_x = (reach_x * depth) * (64'sd1 <<< BOUND_SHIFT);
        reach_y = (reach_y * depth) * (64'sd1 <<< BOUND_SHIFT);
        return ((lat < 0 ? -lat : lat) <= reach_x) && ((vert < 0 ? -vert : vert) <= reach_y);
    endfunction

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] verdict check: %s", $time, msg);
        end
        mismatches = mismatches + 1;
    endtask

    always @(posedge aclk) begin : track
        verdict_t due;
        if (!aresetn) begin
            cam_pos      <= '0;
            right_vec    <= '0;
            up_vec       <= '0;
            fwd_vec      <= '0;
            near_lim     <= '0;
            far_lim      <= FAR_LIMIT_RESET;
            tan_w        <= TAN_RESET;
            tan_h        <= TAN_RESET;
            verdict_q.delete();
            verdicts_due <= 0;
            mismatches   = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_CAMERA_POSITION: cam_pos   <= cfg_data;
                    REG_BASIS_RIGHT:     right_vec <= cfg_data;
                    REG_BASIS_UP:        up_vec    <= cfg_data;
                    REG_BASIS_FORWARD:   fwd_vec   <= cfg_data;
                    REG_NEAR_LIMIT:      near_lim  <= cfg_data[LIMIT_W-1:0];
                    REG_FAR_LIMIT:       far_lim   <= cfg_data[LIMIT_W-1:0];
                    REG_TAN_HALF_WIDTH:  tan_w     <= cfg_data[TAN_W-1:0];
                    REG_TAN_HALF_HEIGHT: tan_h     <= cfg_data[TAN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(verdict_t'{frustum_inside(s_tdata), s_tlast});
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report($sformatf("result item inside=%0b last=%0b with no point waiting",
                                     m_tdata[0], m_tlast));
                end else begin
                    due = verdict_q.pop_front();
                    if (m_tdata[0] !== due.in_view) begin
                        report($sformatf("inside_res %0b, predicted %0b",
                                         m_tdata[0], due.in_view));
                    end
                    if (m_tlast !== due.batch_done) begin
                        report($sformatf("batch_done %0b, predicted %0b", m_tlast, due.batch_done));
                    end
                end
            end
            verdicts_due <= verdict_q.size();
        end
    end

endmodule

/* dv/tb_point_frustum_test.sv */
`timescale 1ns / 1ps
// Testbench top for point_frustum_test: clock, reset, config phases and point
// stream with random idling on both sides. Depends on pft_pkg, the block and
// frustum_verdict_checker.
module tb_point_frustum_test;
    import pft_pkg::*;

    localparam int COORD_W        = COORD_WIDTH_DEF;
    localparam int S_W            = ((3 * COORD_W + 7) / 8) * 8;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int STUCK_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 20;

    // Q2.14 unit axes and a 45 degree turn about y, packed {z, y, x}
    localparam logic [CFG_DATA_W-1:0] AXIS_X    = {16'h0000, 16'h0000, 16'h4000};
    localparam logic [CFG_DATA_W-1:0] AXIS_Y    = {16'h0000, 16'h4000, 16'h0000};
    localparam logic [CFG_DATA_W-1:0] AXIS_Z    = {16'h4000, 16'h0000, 16'h0000};
    localparam logic [CFG_DATA_W-1:0] ROT_RIGHT = {16'hD2BF, 16'h0000, 16'h2D41};
    localparam logic [CFG_DATA_W-1:0] ROT_FWD   = {16'h2D41, 16'h0000, 16'h2D41};

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata  = '0;   // point_x, point_y, point_z
    logic                  s_tlast  = 1'b0; // end_of_batch
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // inside_res
    logic                  m_tlast;         // batch_done

    int verdicts_due;
    int mismatches;
    int stuck_cycles = 0;
    int calm_left    = 0;
    bit squeeze_req  = 1'b0;

    // copy of the frustum used only to aim points
    logic [COORD_W-1:0] cam_sh [3] = '{default: '0};
    int near_sh = 0;
    int far_sh  = 32767;
    int tanw_sh = 4096;
    int tanh_sh = 4096;

    always #5 aclk = ~aclk;

    point_frustum_test #(
        .COORD_WIDTH (COORD_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    frustum_verdict_checker #(
        .COORD_W (COORD_W)
    ) u_verdicts (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .verdicts_due (verdicts_due),
        .mismatches   (mismatches)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 96) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // offset around +-reach, hitting the edge and one step past it often
    function automatic int aim_offset(input int reach);
        int r;
        r = $urandom_range(7);
        if (r < 5) return int'($urandom_range(2 * reach + 4)) - reach - 2;
        if (r == 5) return reach;
        if (r == 6) return -reach;
        return $urandom_range(1) ? reach + 1 : -reach - 1;
    endfunction

    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic [COORD_W-1:0] pz, input logic eob);
        int gap;
        gap = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else begin
            gap = idle_gap();
            if ($urandom_range(9) == 0) calm_left = $urandom_range(40, 10);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({pz, py, px});
        s_tlast  <= eob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Points aimed at the frustum as if the basis were the unit axes, plus noise
    task automatic send_random(input int count);
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        int lo;
        int hi;
        int dz;
        int reach_x;
        int reach_y;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 3) begin
                px = COORD_W'($urandom());
                py = COORD_W'($urandom());
                pz = COORD_W'($urandom());
            end else begin
                lo = near_sh - 64;
                hi = (far_sh > near_sh) ? far_sh + 64 : lo + 512;
                dz = lo + int'($urandom_range(hi - lo));
                reach_x = (dz > 0) ? int'((longint'(tanw_sh) * dz) / 4096) : 0;
                reach_y = (dz > 0) ? int'((longint'(tanh_sh) * dz) / 4096) : 0;
                px = cam_sh[0] + COORD_W'(aim_offset(reach_x));
                py = cam_sh[1] + COORD_W'(aim_offset(reach_y));
                pz = cam_sh[2] + COORD_W'(dz);
            end
            send_point(px, py, pz, $urandom_range(7) == 0);
        end
    endtask

    // stop offering and let every result come back before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic program_frustum(input logic [CFG_DATA_W-1:0] cam,
                                   input logic [CFG_DATA_W-1:0] right,
                                   input logic [CFG_DATA_W-1:0] up,
                                   input logic [CFG_DATA_W-1:0] fwd,
                                   input logic [LIMIT_W-1:0] near, input logic [LIMIT_W-1:0] far,
                                   input logic [TAN_W-1:0] tw, input logic [TAN_W-1:0] th);
        write_reg(REG_CAMERA_POSITION, cam);
        write_reg(REG_BASIS_RIGHT, right);
        write_reg(REG_BASIS_UP, up);
        write_reg(REG_BASIS_FORWARD, fwd);
        write_reg(REG_NEAR_LIMIT, CFG_DATA_W'(near));
        write_reg(REG_FAR_LIMIT, CFG_DATA_W'(far));
        write_reg(REG_TAN_HALF_WIDTH, CFG_DATA_W'(tw));
        write_reg(REG_TAN_HALF_HEIGHT, CFG_DATA_W'(th));
        cfg_we <= 1'b0;
        @(posedge aclk);
        near_sh = int'($signed(near));
        far_sh  = int'($signed(far));
        tanw_sh = int'(tw);
        tanh_sh = int'(th);
        for (int i = 0; i < 3; i++) cam_sh[i] = cam[i*COORD_W +: COORD_W];
    endtask

    initial begin : result_sink
        int gap;
        bit squeezed;
        squeezed = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            // one long hold-off so the pipeline fills and stalls its input
            if (squeeze_req && !squeezed) begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(40, 1)) @(posedge aclk);
            gap = idle_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setup: zero basis puts every point at the apex, all inside
        send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_point(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
        drain();

        // unit axes, near 1.0, far 64.0, 90 degree field of view
        program_frustum('0, AXIS_X, AXIS_Y, AXIS_Z, 16'h0100, 16'h4000, 16'd4096, 16'd4096);
        send_point(16'h0000, 16'h0000, 16'h0100, 1'b0);  // on near plane
        send_point(16'h0000, 16'h0000, 16'h00FF, 1'b0);  // just short of near
        send_point(16'h0000, 16'h0000, 16'h4000, 1'b0);  // on far plane
        send_point(16'h0000, 16'h0000, 16'h4001, 1'b1);  // just past far
        send_point(16'h0200, 16'h0000, 16'h0200, 1'b0);  // on right side plane
        send_point(16'h0201, 16'h0000, 16'h0200, 1'b0);
        send_point(16'hFE00, 16'h0000, 16'h0200, 1'b0);
        send_point(16'hFDFF, 16'h0000, 16'h0200, 1'b1);
        send_point(16'h0000, 16'h0200, 16'h0200, 1'b0);
        send_point(16'h0000, 16'hFDFF, 16'h0200, 1'b1);
        squeeze_req = 1'b1;
        send_random(300);
        drain();

        // camera off the origin, depth range straddling zero
        program_frustum({16'h0032, 16'hFF38, 16'h0064}, AXIS_X, AXIS_Y, AXIS_Z,
                        16'hF800, 16'h0800, 16'd8192, 16'd2048);
        send_point(16'h0064, 16'hFF38, 16'h0032, 1'b0);  // zero depth, zero offset
        send_point(16'h0065, 16'hFF38, 16'h0032, 1'b0);  // zero depth, offset
        send_point(16'h0064, 16'hFF38, 16'h0031, 1'b1);  // negative depth
        send_random(200);
        drain();

        program_frustum({16'hFE00, 16'h0100, 16'h0300}, ROT_RIGHT, AXIS_Y, ROT_FWD,
                        16'h0080, 16'h3000, 16'd6000, 16'd3000);
        send_random(200);
        drain();

        // register extremes
        program_frustum({16'h8000, 16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF, 16'h8000},
                        {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h8000, 16'h8000},
                        16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_random(150);
        drain();

        // zero field of view: only points on the axis survive
        program_frustum('0, AXIS_X, AXIS_Y, AXIS_Z, 16'h0000, 16'h7FFF, 16'd0, 16'd0);
        send_point(16'h0000, 16'h0000, 16'h0100, 1'b0);
        send_point(16'h0001, 16'h0000, 16'h0100, 1'b1);
        send_random(150);
        drain();

        // near above far rejects everything
        program_frustum('0, AXIS_X, AXIS_Y, AXIS_Z, 16'h7FFF, 16'h8000, 16'd4096, 16'd4096);
        send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_random(100);
        drain();

        program_frustum(CFG_DATA_W'({$urandom(), $urandom()}),
                        CFG_DATA_W'({$urandom(), $urandom()}),
                        CFG_DATA_W'({$urandom(), $urandom()}),
                        CFG_DATA_W'({$urandom(), $urandom()}),
                        LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                        TAN_W'($urandom()), TAN_W'($urandom()));
        send_random(150);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
